### rtl/hvd_pkg.sv
// Shared types, constants and a helper function for the haversine distance pipeline.
package hvd_pkg;

  // Payload widths
  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int DIST_W = 35;
  localparam int RAD_W  = 23;

  // Fixed point: Q32 fractions, CORDIC datapath width, unsigned product operands
  localparam int FRAC      = 32;
  localparam int ANG_W     = 36;
  localparam int QW        = 34;
  localparam int SQ_STAGES = 32;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_RADIUS = '0;
  localparam logic [RAD_W-1:0]  RADIUS_RESET = 23'd6371000;

  // Coordinate limits
  localparam logic signed [LAT_W-1:0] LAT_LIMIT = 31'sd900000000;
  localparam logic signed [LON_W-1:0] LON_LIMIT = 32'sd1800000000;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic [QW-1:0]           uq_t;
  typedef logic [FRAC:0]           root_t;

  // Angles and gain in Q32
  localparam ang_t QUARTER_PI = 36'sh0C90FDAA2;
  localparam ang_t HALF_PI    = 36'sh1921FB544;
  localparam ang_t PI_Q       = 36'sh3243F6A89;
  localparam ang_t INV_GAIN   = 36'sh09B74EDA8;
  localparam root_t ONE_Q     = {1'b1, {FRAC{1'b0}}};

  // Stage control handed from the top to each pipeline section
  typedef struct packed {
    logic en;
    logic vld;
  } hvd_ctl_t;

  // atan(2^-idx) in Q32: series summed in Q62 with truncated terms, rounded half up
  function automatic ang_t atan_q32(input int unsigned idx);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned e;
    sum = '0;
    if (idx == 0) return QUARTER_PI;
    for (int unsigned k = 0; k < 32; k++) begin
      e = idx * (2 * k + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k[0]) sum = sum - term;
        else sum = sum + term;
      end
    end
    return ANG_W'((sum + 64'd536870912) >> 30);
  endfunction

endpackage

### rtl/hvd_if.sv
// Valid/ready channel interfaces for coordinate pairs and distances.
interface hvd_in_if;
  import hvd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] start_lat;
  logic signed [LON_W-1:0] start_lon;
  logic signed [LAT_W-1:0] end_lat;
  logic signed [LON_W-1:0] end_lon;
  modport source (output valid, start_lat, start_lon, end_lat, end_lon, input ready);
  modport sink (input valid, start_lat, start_lon, end_lat, end_lon, output ready);
endinterface

interface hvd_out_if;
  import hvd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_mm;
  modport source (output valid, distance_mm, input ready);
  modport sink (input valid, distance_mm, output ready);
endinterface

### rtl/hvd_front.sv
// Front end: coordinate saturation, differences, degree to radian scaling, longitude fold.
module hvd_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hvd_pkg::hvd_ctl_t               ctl,
  input  logic signed [hvd_pkg::LAT_W-1:0] start_lat,
  input  logic signed [hvd_pkg::LON_W-1:0] start_lon,
  input  logic signed [hvd_pkg::LAT_W-1:0] end_lat,
  input  logic signed [hvd_pkg::LON_W-1:0] end_lon,
  output logic                            out_vld,
  output hvd_pkg::ang_t                   ang [4]
);
  import hvd_pkg::*;

  // floor(pi * 2^64 / D), pi carried with 64 fractional bits
  localparam logic [127:0] PI_Q64   = {62'd0, 2'd3, 64'h243F6A8885A308D3};
  localparam logic [127:0] K_FULL_W = PI_Q64 / 128'd1800000000;
  localparam logic [127:0] K_HALF_W = PI_Q64 / 128'd3600000000;
  localparam int KW = 35;
  localparam int SW = LON_W + 1;

  logic signed [LAT_W-1:0] lat1_c, lat2_c;
  logic signed [LON_W-1:0] lon1_c, lon2_c;

  logic                 s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic signed [SW-1:0] s1_src_r [4];
  logic [63:0]          s2_plo_r [4];
  logic [KW-1:0]        s2_phi_r [4];
  logic                 s2_neg_r [4];
  ang_t                 s3_ang_r [4];
  ang_t                 s4_ang_r [4];

  // Saturate to the legal coordinate ranges
  always_comb begin
    if (start_lat > LAT_LIMIT) lat1_c = LAT_LIMIT;
    else if (start_lat < -LAT_LIMIT) lat1_c = -LAT_LIMIT;
    else lat1_c = start_lat;
    if (end_lat > LAT_LIMIT) lat2_c = LAT_LIMIT;
    else if (end_lat < -LAT_LIMIT) lat2_c = -LAT_LIMIT;
    else lat2_c = end_lat;
    if (start_lon > LON_LIMIT) lon1_c = LON_LIMIT;
    else if (start_lon < -LON_LIMIT) lon1_c = -LON_LIMIT;
    else lon1_c = start_lon;
    if (end_lon > LON_LIMIT) lon2_c = LON_LIMIT;
    else if (end_lon < -LON_LIMIT) lon2_c = -LON_LIMIT;
    else lon2_c = end_lon;
  end

  // Stage 1: lanes are lat1, lat2, lat difference, lon difference
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s1_src_r[0] <= SW'(lat1_c);
      s1_src_r[1] <= SW'(lat2_c);
      s1_src_r[2] <= SW'(lat2_c) - SW'(lat1_c);
      s1_src_r[3] <= SW'(lon2_c) - SW'(lon1_c);
    end
  end

  // Stages 2 and 3: magnitude times radian constant, rounded at Q32, sign restored
  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam logic [KW-1:0] K = (l < 2) ? K_FULL_W[KW-1:0] : K_HALF_W[KW-1:0];
    logic signed [SW-1:0] abs_v;
    logic [31:0]          mag_in;
    logic [64:0]          rnd;
    ang_t                 mag;

    always_comb begin
      abs_v  = s1_src_r[l][SW-1] ? -s1_src_r[l] : s1_src_r[l];
      mag_in = abs_v[31:0];
      rnd    = 65'(s2_plo_r[l]) + 65'(64'h80000000);
      mag    = ANG_W'(s2_phi_r[l]) + ANG_W'(rnd[64:32]);
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        s2_plo_r[l] <= 64'(mag_in) * 64'(K[31:0]);
        s2_phi_r[l] <= KW'(mag_in) * KW'(K[KW-1:32]);
        // longitude term is used by magnitude only
        s2_neg_r[l] <= (l == 3) ? 1'b0 : s1_src_r[l][SW-1];
        s3_ang_r[l] <= s2_neg_r[l] ? -mag : mag;
      end
    end
  end

  // Stage 4: fold the longitude half difference into [0, pi/2]
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s4_ang_r[0] <= s3_ang_r[0];
      s4_ang_r[1] <= s3_ang_r[1];
      s4_ang_r[2] <= s3_ang_r[2];
      s4_ang_r[3] <= (s3_ang_r[3] > HALF_PI) ? PI_Q - s3_ang_r[3] : s3_ang_r[3];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (ctl.en) begin
      s1_vld_r <= ctl.vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  assign out_vld = s4_vld_r;
  assign ang     = s4_ang_r;

endmodule

### rtl/hvd_rot.sv
// Four-lane rotation-mode CORDIC, one micro-rotation per pipeline stage (cos, sin).
module hvd_rot #(
  parameter int STAGES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hvd_pkg::hvd_ctl_t ctl,
  input  hvd_pkg::ang_t     ang [4],
  output logic              out_vld,
  output hvd_pkg::ang_t     cos_o [4],
  output hvd_pkg::ang_t     sin_o [4]
);
  import hvd_pkg::*;

  logic vld_r [STAGES];
  ang_t x_r   [STAGES][4];
  ang_t y_r   [STAGES][4];
  ang_t z_r   [STAGES][4];

  for (genvar i = 0; i < STAGES; i++) begin : g_stg
    localparam ang_t ATAN_I = atan_q32(i);
    ang_t x_in [4], y_in [4], z_in [4];
    ang_t x_nxt [4], y_nxt [4], z_nxt [4];
    logic v_in;

    // Stage input: start vector at the first stage, previous stage after
    if (i == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          x_in[l] = INV_GAIN;
          y_in[l] = '0;
          z_in[l] = ang[l];
        end
        v_in = ctl.vld;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          x_in[l] = x_r[i-1][l];
          y_in[l] = y_r[i-1][l];
          z_in[l] = z_r[i-1][l];
        end
        v_in = vld_r[i-1];
      end
    end

    // Micro-rotation toward zero residual angle
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (z_in[l] >= 0) begin
          x_nxt[l] = x_in[l] - (y_in[l] >>> i);
          y_nxt[l] = y_in[l] + (x_in[l] >>> i);
          z_nxt[l] = z_in[l] - ATAN_I;
        end else begin
          x_nxt[l] = x_in[l] + (y_in[l] >>> i);
          y_nxt[l] = y_in[l] - (x_in[l] >>> i);
          z_nxt[l] = z_in[l] + ATAN_I;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i] <= 1'b0;
      else if (ctl.en) vld_r[i] <= v_in;
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign cos_o   = x_r[STAGES-1];
  assign sin_o   = y_r[STAGES-1];

endmodule

### rtl/hvd_sqrt.sv
// Two-lane pipelined Q32 square root, restoring shift-subtract, one result bit per stage.
module hvd_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  hvd_pkg::hvd_ctl_t ctl,
  input  hvd_pkg::root_t    u [2],
  output logic              out_vld,
  output hvd_pkg::root_t    root [2]
);
  import hvd_pkg::*;

  logic        vld_r  [SQ_STAGES];
  logic [63:0] n_r    [SQ_STAGES][2];
  logic [63:0] res_r  [SQ_STAGES][2];
  logic        full_r [SQ_STAGES][2];

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stg
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] n_in [2], res_in [2], n_nxt [2], res_nxt [2], trial [2];
    logic        full_in [2];
    logic        v_in;

    if (j == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          n_in[l]    = {u[l][FRAC-1:0], {FRAC{1'b0}}};
          res_in[l]  = '0;
          full_in[l] = u[l][FRAC];
        end
        v_in = ctl.vld;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          n_in[l]    = n_r[j-1][l];
          res_in[l]  = res_r[j-1][l];
          full_in[l] = full_r[j-1][l];
        end
        v_in = vld_r[j-1];
      end
    end

    // Try to subtract the next trial square
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = res_in[l] + BIT;
        if (n_in[l] >= trial[l]) begin
          n_nxt[l]   = n_in[l] - trial[l];
          res_nxt[l] = (res_in[l] >> 1) + BIT;
        end else begin
          n_nxt[l]   = n_in[l];
          res_nxt[l] = res_in[l] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        n_r[j]    <= n_nxt;
        res_r[j]  <= res_nxt;
        full_r[j] <= full_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[j] <= 1'b0;
      else if (ctl.en) vld_r[j] <= v_in;
    end
  end

  // An input of exactly one has root one
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      root[l] = full_r[SQ_STAGES-1][l] ? ONE_Q : res_r[SQ_STAGES-1][l][FRAC:0];
    end
  end

  assign out_vld = vld_r[SQ_STAGES-1];

endmodule

### rtl/hvd_vec.sv
// Vectoring-mode CORDIC: angle of (x, y), one micro-rotation per pipeline stage.
module hvd_vec #(
  parameter int STAGES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hvd_pkg::hvd_ctl_t ctl,
  input  hvd_pkg::ang_t     x_i,
  input  hvd_pkg::ang_t     y_i,
  output logic              out_vld,
  output hvd_pkg::ang_t     z_o
);
  import hvd_pkg::*;

  logic vld_r [STAGES];
  ang_t x_r   [STAGES];
  ang_t y_r   [STAGES];
  ang_t z_r   [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stg
    localparam ang_t ATAN_I = atan_q32(i);
    ang_t x_in, y_in, z_in, x_nxt, y_nxt, z_nxt;
    logic v_in;

    if (i == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = '0;
      assign v_in = ctl.vld;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign v_in = vld_r[i-1];
    end

    // Rotate y toward zero, accumulate the angle
    always_comb begin
      if (y_in >= 0) begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + ATAN_I;
      end else begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i] <= 1'b0;
      else if (ctl.en) vld_r[i] <= v_in;
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign z_o     = z_r[STAGES-1];

endmodule

### rtl/haversine_distance.sv
// Top level: haversine great-circle distance pipeline with APB radius register.
//
//   channel  | direction | handshake      | payload
//   in_ch    | in        | valid/ready    | start_lat, start_lon, end_lat, end_lon
//   out_ch   | out       | valid/ready    | distance_mm
//   apb      | in/out    | psel/penable   | sphere_radius_m at byte 0
//
// One transfer is accepted per cycle while the pipeline is not held. The path
// runs through four front stages, two CORDIC pipelines, three product stages,
// a 32-stage square root and two scaling stages. Reset (rst_n low, synchronous)
// clears all valid bits and loads the radius with 6371000 m. The whole pipeline
// holds while the output register is full and out_ch.ready is low.
module haversine_distance #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  hvd_in_if.sink                      in_ch,
  hvd_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hvd_pkg::APB_AW-1:0]  paddr,
  input  logic [hvd_pkg::APB_DW-1:0]  pwdata,
  output logic [hvd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import hvd_pkg::*;

  // Q32 product rounded half up
  function automatic uq_t mulq(input uq_t a, input uq_t b);
    logic [2*QW-1:0] p;
    p = (2*QW)'(a) * (2*QW)'(b) + (2*QW)'(64'h80000000);
    return QW'(p >> FRAC);
  endfunction

  logic             en;
  logic [RAD_W-1:0] radius_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (psel && penable && pwrite && paddr[APB_AW-1:2] == REG_RADIUS) begin
      radius_r <= pwdata[RAD_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1:2] == REG_RADIUS) ? APB_DW'(radius_r) : '0;

  // Global advance: the pipeline moves unless the output register is stuck
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Front end
  logic front_vld;
  ang_t front_ang [4];

  hvd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       ('{en: en, vld: in_ch.valid}),
    .start_lat (in_ch.start_lat),
    .start_lon (in_ch.start_lon),
    .end_lat   (in_ch.end_lat),
    .end_lon   (in_ch.end_lon),
    .out_vld   (front_vld),
    .ang       (front_ang)
  );

  // Sin and cos of lat1, lat2, half dlat, half dlon
  logic rot_vld;
  ang_t rot_cos [4];
  ang_t rot_sin [4];

  hvd_rot #(.STAGES(CORDIC_STAGES)) u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     ('{en: en, vld: front_vld}),
    .ang     (front_ang),
    .out_vld (rot_vld),
    .cos_o   (rot_cos),
    .sin_o   (rot_sin)
  );

  // Product stage 1: squares of the sines and cos(lat1)*cos(lat2)
  uq_t  c1, c2, sa_m, sb_m;
  ang_t sa_abs, sb_abs;
  always_comb begin
    c1     = rot_cos[0][ANG_W-1] ? '0 : rot_cos[0][QW-1:0];
    c2     = rot_cos[1][ANG_W-1] ? '0 : rot_cos[1][QW-1:0];
    sa_abs = rot_sin[2][ANG_W-1] ? -rot_sin[2] : rot_sin[2];
    sb_abs = rot_sin[3][ANG_W-1] ? -rot_sin[3] : rot_sin[3];
    sa_m   = sa_abs[QW-1:0];
    sb_m   = sb_abs[QW-1:0];
  end

  logic  m1_vld_r, m2_vld_r, m3_vld_r;
  uq_t   m1_sa2_r, m1_sb2_r, m1_c12_r, m2_sa2_r, m2_t_r;
  root_t m3_h_r, m3_c_r;
  logic [QW:0] h_sum;
  root_t       h_sat;

  always_comb begin
    h_sum = (QW+1)'(m2_sa2_r) + (QW+1)'(m2_t_r);
    h_sat = (h_sum > (QW+1)'(ONE_Q)) ? ONE_Q : h_sum[FRAC:0];
  end

  // Product stages 2 and 3: haversine term, saturated, and its complement
  always_ff @(posedge clk) begin
    if (en) begin
      m1_sa2_r <= mulq(sa_m, sa_m);
      m1_sb2_r <= mulq(sb_m, sb_m);
      m1_c12_r <= mulq(c1, c2);
      m2_sa2_r <= m1_sa2_r;
      m2_t_r   <= mulq(m1_c12_r, m1_sb2_r);
      m3_h_r   <= h_sat;
      m3_c_r   <= ONE_Q - h_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= rot_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  // Square roots of 1-h (lane 0) and h (lane 1)
  root_t sq_in [2];
  root_t sq_out [2];
  logic  sq_vld;
  assign sq_in[0] = m3_c_r;
  assign sq_in[1] = m3_h_r;

  hvd_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     ('{en: en, vld: m3_vld_r}),
    .u       (sq_in),
    .out_vld (sq_vld),
    .root    (sq_out)
  );

  // Half central angle = atan2(sqrt(h), sqrt(1-h))
  logic vec_vld;
  ang_t vec_z;

  hvd_vec #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     ('{en: en, vld: sq_vld}),
    .x_i     ($signed({{(ANG_W-FRAC-1){1'b0}}, sq_out[0]})),
    .y_i     ($signed({{(ANG_W-FRAC-1){1'b0}}, sq_out[1]})),
    .out_vld (vec_vld),
    .z_o     (vec_z)
  );

  // Scaling: angle * 2 * radius, then to millimetres with rounding
  localparam int ZW = FRAC + 1;
  localparam int PW = ZW + RAD_W + 1;
  localparam int MW = PW + 11;

  logic [ZW-1:0]     z_pos;
  logic [PW-1:0]     s1_q_r;
  logic              s1_vld_r;
  logic [MW-1:0]     mm_full;
  logic [DIST_W-1:0] out_mm_r;

  always_comb begin
    z_pos   = vec_z[ANG_W-1] ? '0 : vec_z[ZW-1:0];
    mm_full = MW'(s1_q_r) * MW'(1000) + MW'(64'h80000000);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_q_r   <= PW'(z_pos) * PW'({radius_r, 1'b0});
      out_mm_r <= mm_full[FRAC +: DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= vec_vld;
      out_vld_r <= s1_vld_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.distance_mm = out_mm_r;

endmodule
